// ===== hw/rtl/dldu_pkg.sv =====
// shared constants, types and helpers for the display line dirty update block
// no dependencies; imported by dldu_cache, display_line_dirty_update and tb
`default_nettype none

package dldu_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 20;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CUR_W  = $clog2(COLS + 1);
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd200;

    // word index of the interval register on the config port
    localparam logic REG_MIN_INTERVAL = 1'b0;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clear;
    } cache_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r * COLS + c);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dldu_cache.sv =====
// shadow character cache: one synchronous memory with registered read data
// valid bit per cell so reset and clear read back as spaces; uses dldu_pkg
`default_nettype none

module dldu_cache (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dldu_pkg::cache_req_t req,
    output logic [7:0]              rd_char
);
    import dldu_pkg::*;

    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rvalid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // a cell never written since reset or clear holds a space
    assign rd_char = rvalid_reg ? rdata_reg : CHAR_SPACE;

    // the sequencer never reads and writes one cell in the same cycle
    a_no_rw_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (req.rd_en && req.wr_en) |-> (req.rd_addr != req.wr_addr))
        else $error("cache read and write hit the same cell");

    // clear comes only from an idle sequencer, never alongside a write
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        req.clear |-> (!req.wr_en && !req.rd_en))
        else $error("cache clear overlaps an access");

endmodule

`default_nettype wire

// ===== hw/rtl/display_line_dirty_update.sv =====
// top level of the display line dirty update block: stream ports, config port,
// write sequencer and output register; uses dldu_pkg and dldu_cache
`default_nettype none

// Takes line writes one character per transfer and emits only the display
// cells whose character differs from the shadow cache. A text character's
// transfer reads the cache; the compare and update follow in the next cycle,
// held while a changed cell cannot enter the output register. A terminator
// (zero character) walks the rest of the row at one cell per cycle unless a
// changed cell waits on the output side, and holds the input until the walk
// is done. A clear or an ignored item is done in the transfer itself. Reset
// and clear are instant: the cache carries a valid bit per cell, so no
// clearing pass runs.
module display_line_dirty_update (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // row[2:0], col[7:3], ch[15:8], now_ms[47:16]
    input  wire logic [1:0]  s_tuser,  // cmd[0], first[1]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // out_row[1:0], out_col[6:2], out_char[14:7], pad[15]
    output logic             m_tlast,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dldu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CHAR = 4'b0010,
        ST_PAD  = 4'b0100,
        ST_END  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             active_reg, active_next;
    logic [ROW_W-1:0] wrow_reg, wrow_next;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [31:0]      stamp_reg, stamp_next;
    logic [7:0]       char_reg, char_next;
    logic [COL_W-1:0] pad_col_reg, pad_col_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0] pend_col_reg, pend_col_next;
    logic [31:0]      row_time_reg [ROWS];
    logic [15:0]      min_interval_reg;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_row_reg, out_row_next;
    logic [4:0]       out_col_reg, out_col_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic             time_we;
    logic [ROW_W-1:0] time_row;
    logic [31:0]      time_val;

    cache_req_t       cache_req;
    logic [7:0]       cache_char;

    logic             in_cmd, in_first;
    logic [2:0]       in_row;
    logic [4:0]       in_col;
    logic [7:0]       in_ch;
    logic [31:0]      in_now;
    logic             accept;
    logic             out_free;
    logic [31:0]      elapsed;
    logic             eff_active;
    logic [ROW_W-1:0] eff_row;
    logic [CUR_W-1:0] eff_cur;
    logic [31:0]      eff_stamp;
    logic             diff;
    logic             cfg_write;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[7:3];
    assign in_ch    = s_tdata[15:8];
    assign in_now   = s_tdata[47:16];
    assign in_cmd   = s_tuser[0];
    assign in_first = s_tuser[1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign elapsed  = in_now - row_time_reg[in_row[ROW_W-1:0]];

    dldu_cache u_cache (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cache_req),
        .rd_char (cache_char)
    );

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        wrow_next       = wrow_reg;
        cursor_next     = cursor_reg;
        stamp_next      = stamp_reg;
        char_next       = char_reg;
        pad_col_next    = pad_col_reg;
        pend_valid_next = pend_valid_reg;
        pend_col_next   = pend_col_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        time_we         = 1'b0;
        time_row        = wrow_reg;
        time_val        = stamp_reg;
        cache_req       = '0;
        eff_active      = active_reg;
        eff_row         = wrow_reg;
        eff_cur         = cursor_reg;
        eff_stamp       = stamp_reg;
        diff            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd)
                    begin
                        cache_req.clear = 1'b1;
                        active_next     = 1'b0;
                    end
                    else
                    begin
                        if (in_first)
                        begin
                            eff_active = (int'(in_row) < ROWS) && (int'(in_col) < COLS)
                                         && (elapsed >= {16'd0, min_interval_reg});
                            eff_row    = in_row[ROW_W-1:0];
                            eff_cur    = CUR_W'(in_col);
                            eff_stamp  = in_now;
                        end
                        wrow_next   = eff_row;
                        cursor_next = eff_cur;
                        stamp_next  = eff_stamp;
                        active_next = eff_active;
                        if (eff_active)
                        begin
                            if (in_ch != CHAR_NUL)
                            begin
                                if (int'(eff_cur) < COLS)
                                begin
                                    cache_req.rd_en   = 1'b1;
                                    cache_req.rd_addr = cell_addr(eff_row, eff_cur[COL_W-1:0]);
                                    char_next         = in_ch;
                                    cursor_next       = eff_cur + CUR_W'(1);
                                    state_next        = ST_CHAR;
                                end
                            end
                            else
                            begin
                                // terminator: stamp now, pad the rest of the row
                                time_we     = 1'b1;
                                time_row    = eff_row;
                                time_val    = eff_stamp;
                                active_next = 1'b0;
                                cursor_next = CUR_W'(COLS);
                                if (int'(eff_cur) < COLS)
                                begin
                                    cache_req.rd_en   = 1'b1;
                                    cache_req.rd_addr = cell_addr(eff_row, eff_cur[COL_W-1:0]);
                                    pad_col_next      = eff_cur[COL_W-1:0];
                                    state_next        = ST_PAD;
                                end
                            end
                        end
                    end
                end
            end

            ST_CHAR:
            begin
                diff = (cache_char != char_reg);
                if (!diff)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cache_req.wr_en   = 1'b1;
                    cache_req.wr_addr = cell_addr(wrow_reg, COL_W'(cursor_reg - CUR_W'(1)));
                    cache_req.wr_data = char_reg;
                    out_valid_next    = 1'b1;
                    out_row_next      = 2'(wrow_reg);
                    out_col_next      = 5'(cursor_reg - CUR_W'(1));
                    out_char_next     = char_reg;
                    out_last_next     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            ST_PAD:
            begin
                diff = (cache_char != CHAR_SPACE);
                // a changed cell is held back one step so the final one can carry last
                if (!(diff && pend_valid_reg && !out_free))
                begin
                    if (diff)
                    begin
                        cache_req.wr_en   = 1'b1;
                        cache_req.wr_addr = cell_addr(wrow_reg, pad_col_reg);
                        cache_req.wr_data = CHAR_SPACE;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = 2'(wrow_reg);
                            out_col_next   = 5'(pend_col_reg);
                            out_char_next  = CHAR_SPACE;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_col_next   = pad_col_reg;
                    end
                    if (pad_col_reg == COL_W'(COLS - 1))
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        cache_req.rd_en   = 1'b1;
                        cache_req.rd_addr = cell_addr(wrow_reg, pad_col_reg + COL_W'(1));
                        pad_col_next      = pad_col_reg + COL_W'(1);
                    end
                end
            end

            ST_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = 2'(wrow_reg);
                    out_col_next    = 5'(pend_col_reg);
                    out_char_next   = CHAR_SPACE;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            wrow_reg       <= '0;
            cursor_reg     <= '0;
            stamp_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                row_time_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            wrow_reg       <= wrow_next;
            cursor_reg     <= cursor_next;
            stamp_reg      <= stamp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (time_we)
            begin
                row_time_reg[time_row] <= time_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        pad_col_reg   <= pad_col_next;
        pend_col_reg  <= pend_col_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_MIN_INTERVAL))
        begin
            min_interval_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_INTERVAL) ? {16'd0, min_interval_reg} : 32'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_PAD || state_reg == ST_END))
        else $error("held-back pad result outside the padding walk");

    // a rejected first transfer may leave any column here, but no open write does
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (int'(cursor_reg) <= COLS))
        else $error("write cursor beyond the row");

    a_term_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_cmd && in_ch == CHAR_NUL) |=> !active_reg)
        else $error("line write still open after its terminator");

    a_walk_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |=> (state_reg == ST_PAD || state_reg == ST_END))
        else $error("padding walk left without draining its last result");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for display_line_dirty_update: streams line writes, clears and stray
// characters, keeps its own shadow of the display and checks every cell rewrite
// depends on dldu_pkg and the rtl of display_line_dirty_update
module tb;
    import dldu_pkg::*;

    localparam logic CMD_TEXT  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [2:0] ADDR_MIN_INTERVAL = 3'(4 * REG_MIN_INTERVAL);
    localparam int CYCLE_LIMIT = 1000000;
    // terminator walk plus output register, with margin
    localparam int DRAIN_CYCLES = COLS + 8;

    typedef struct packed {
        logic        cmd;
        logic        first;
        logic [2:0]  row;
        logic [4:0]  col;
        logic [7:0]  ch;
        logic [31:0] now;
    } disp_item_t;

    typedef struct packed {
        logic [1:0] row;
        logic [4:0] col;
        logic [7:0] chr;
        logic       last;
    } cell_upd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // row[2:0], col[7:3], ch[15:8], now_ms[47:16]
    logic [1:0]  s_tuser = '0;   // cmd[0], first[1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // out_row[1:0], out_col[6:2], out_char[14:7], pad[15]
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    display_line_dirty_update dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the display and line write state
    logic [7:0]  shadow [ROWS*COLS];
    logic [31:0] row_stamp [ROWS];
    logic        line_open;
    logic [1:0]  line_row;
    int          line_cur;
    logic [31:0] line_stamp;
    logic [15:0] min_interval;

    disp_item_t char_q [$];
    cell_upd_t  cell_q [$];
    disp_item_t in_flight;
    int         n_sent = 0;
    int         n_accepted = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         steady_in = 1'b0;
    bit         steady_out = 1'b0;
    logic [31:0] clock_ms = 32'd20000;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return 8'h41 + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] next_step();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, min_interval) + $urandom_range(0, 80);
    endfunction

    // work out which cells one accepted transfer rewrites
    task automatic update_shadow(input disp_item_t it);
        cell_upd_t   hits [$];
        cell_upd_t   h;
        logic [31:0] elapsed;
        int          idx;
        if (it.cmd == CMD_CLEAR)
        begin
            foreach (shadow[i])
                shadow[i] = CHAR_SPACE;
            line_open = 1'b0;
            return;
        end
        if (it.first)
        begin
            line_open = 1'b0;
            if (it.row >= ROWS || it.col >= COLS)
                return;
            elapsed = it.now - row_stamp[it.row];
            if (elapsed < {16'h0, min_interval})
                return;
            line_open = 1'b1;
            line_row = it.row[1:0];
            line_cur = it.col;
            line_stamp = it.now;
        end
        if (!line_open)
            return;
        h.last = 1'b0;
        if (it.ch != CHAR_NUL)
        begin
            // characters past the last column fall off
            if (line_cur < COLS)
            begin
                idx = line_row * COLS + line_cur;
                if (shadow[idx] != it.ch)
                begin
                    shadow[idx] = it.ch;
                    h.row = line_row;
                    h.col = 5'(line_cur);
                    h.chr = it.ch;
                    hits.push_back(h);
                end
                line_cur++;
            end
        end
        else
        begin
            for (int c = line_cur; c < COLS; c++)
            begin
                idx = line_row * COLS + c;
                if (shadow[idx] != CHAR_SPACE)
                begin
                    shadow[idx] = CHAR_SPACE;
                    h.row = line_row;
                    h.col = 5'(c);
                    h.chr = CHAR_SPACE;
                    hits.push_back(h);
                end
            end
            line_cur = COLS;
            row_stamp[line_row] = line_stamp;
            line_open = 1'b0;
        end
        foreach (hits[i])
        begin
            if (i == hits.size() - 1)
                hits[i].last = 1'b1;
            cell_q.push_back(hits[i]);
        end
    endtask

    task automatic push_item(input logic cmd, input logic first, input logic [2:0] row,
                             input logic [4:0] col, input logic [7:0] ch,
                             input logic [31:0] now);
        disp_item_t it;
        it.cmd = cmd;
        it.first = first;
        it.row = row;
        it.col = col;
        it.ch = ch;
        it.now = now;
        char_q.push_back(it);
        n_sent++;
    endtask

    // follow-on character: row, col and time are don't-care
    task automatic push_char(input logic [7:0] ch);
        push_item(CMD_TEXT, 1'b0, 3'($urandom), 5'($urandom), ch, $urandom);
    endtask

    task automatic gen_line(inout int counted);
        logic [2:0] r;
        logic [4:0] c;
        int         kind;
        int         len;
        kind = $urandom_range(0, 99);
        clock_ms += next_step();
        r = (kind < 7) ? 3'($urandom_range(ROWS, 7)) : 3'($urandom_range(0, ROWS - 1));
        c = (kind >= 7 && kind < 13) ? 5'($urandom_range(COLS, 31))
                                     : 5'($urandom_range(0, COLS - 1));
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(COLS - 6, COLS + 6)
                                          : $urandom_range(0, 6);
        push_item(CMD_TEXT, 1'b1, r, c,
                  ($urandom_range(0, 9) == 0) ? CHAR_NUL : pick_char(), clock_ms);
        for (int i = 0; i < len; i++)
            push_char(pick_char());
        // now and then the line is left open and abandoned later
        if ($urandom_range(0, 7) != 0)
            push_char(CHAR_NUL);
        counted += len + 2;
        case ($urandom_range(0, 19))
            0:
            begin
                push_item(CMD_CLEAR, 1'($urandom), 3'($urandom), 5'($urandom),
                          8'($urandom), $urandom);
                counted++;
            end
            1, 2: push_char(pick_char());
            default: ;
        endcase
    endtask

    task automatic apb_access(input bit wr, input logic [15:0] v, output logic [31:0] rd);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_MIN_INTERVAL;
        pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (wr)
            min_interval = v;
    endtask

    task automatic program_interval(input bit do_write, input logic [15:0] v);
        logic [31:0] rd;
        if (do_write)
            apb_access(1'b1, v, rd);
        apb_access(1'b0, '0, rd);
        if (rd !== {16'h0, min_interval})
        begin
            $display("%0t: min_interval_ms readback, expected %0d got %0d",
                     $time, min_interval, rd);
            mismatches++;
        end
    endtask

    task automatic wait_idle();
        while (n_accepted != n_sent || cell_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input side
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                update_shadow(in_flight);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    in_flight = char_q.pop_front();
                    s_tdata <= {in_flight.now, in_flight.ch, in_flight.col, in_flight.row};
                    s_tuser <= {in_flight.first, in_flight.cmd};
                    s_tvalid <= 1'b1;
                    in_gap = steady_in ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        cell_upd_t got;
        cell_upd_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.row = m_tdata[1:0];
                got.col = m_tdata[6:2];
                got.chr = m_tdata[14:7];
                got.last = m_tlast;
                if (cell_q.size() == 0)
                begin
                    $display("%0t: unexpected cell, got row %0d col %0d char %02h last %0b",
                             $time, got.row, got.col, got.chr, got.last);
                    mismatches++;
                end
                else
                begin
                    want = cell_q.pop_front();
                    if (got.row !== want.row || got.col !== want.col ||
                        got.chr !== want.chr || got.last !== want.last)
                    begin
                        $display("%0t: cell mismatch, expected row %0d col %0d char %02h last %0b, got row %0d col %0d char %02h last %0b",
                                 $time, want.row, want.col, want.chr, want.last,
                                 got.row, got.col, got.chr, got.last);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                out_gap = steady_out ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d cells still expected", $time, cell_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int          counted;
        logic [15:0] setting;
        foreach (shadow[i])
            shadow[i] = CHAR_SPACE;
        foreach (row_stamp[i])
            row_stamp[i] = '0;
        line_open = 1'b0;
        line_row = '0;
        line_cur = 0;
        line_stamp = '0;
        min_interval = MIN_INTERVAL_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        program_interval(1'b0, '0);

        // plain line, a repeated space and the top character code
        push_item(CMD_TEXT, 1'b1, 3'd0, 5'd0, 8'h41, 32'd1000);
        push_char(8'h42);
        push_char(CHAR_SPACE);
        push_char(8'hFF);
        push_char(CHAR_NUL);
        // last column, then a character that falls off the row
        push_item(CMD_TEXT, 1'b1, 3'd3, 5'(COLS - 1), 8'h80, 32'd5000);
        push_char(8'h7F);
        push_char(CHAR_NUL);
        // row and column out of range, with a follower that is ignored
        push_item(CMD_TEXT, 1'b1, 3'd7, 5'd0, 8'h78, 32'd9000);
        push_char(8'h79);
        push_item(CMD_TEXT, 1'b1, 3'd0, 5'd31, 8'h78, 32'd9000);
        // too soon after the last write to row 0
        push_item(CMD_TEXT, 1'b1, 3'd0, 5'd0, 8'h7A, 32'd1100);
        push_char(CHAR_NUL);
        // terminator on the first transfer pads the row
        push_item(CMD_TEXT, 1'b1, 3'd0, 5'd2, CHAR_NUL, 32'd2000);
        // open line abandoned by a new first transfer
        push_item(CMD_TEXT, 1'b1, 3'd1, 5'd5, 8'h51, 32'd3000);
        push_item(CMD_TEXT, 1'b1, 3'd2, 5'd0, 8'h52, 32'd3000);
        push_char(CHAR_NUL);
        // clears with all-zero and all-one fields
        push_item(CMD_CLEAR, 1'b0, 3'd0, 5'd0, 8'h00, 32'd0);
        push_item(CMD_CLEAR, 1'b1, 3'd7, 5'd31, 8'hFF, 32'hFFFF_FFFF);
        // text with no open line
        push_char(8'h6B);
        // time difference across the 32-bit wrap
        push_item(CMD_TEXT, 1'b1, 3'd2, 5'd0, 8'h57, 32'hFFFF_FFF0);
        push_char(CHAR_NUL);
        push_item(CMD_TEXT, 1'b1, 3'd2, 5'd0, 8'h56, 32'h0000_0050);
        push_item(CMD_TEXT, 1'b1, 3'd2, 5'd0, 8'h55, 32'h0000_00D0);
        push_char(CHAR_NUL);

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_idle();
            if (phase > 0)
            begin
                case (phase)
                    1: setting = 16'h0000;
                    2: setting = 16'hFFFF;
                    3: setting = 16'($urandom_range(1, 999));
                    default: setting = MIN_INTERVAL_RESET;
                endcase
                program_interval(1'b1, setting);
            end
            steady_in = (phase == 1 || phase == 3);
            steady_out = (phase == 2 || phase == 3);
            counted = 0;
            while (counted < 36)
                gen_line(counted);
        end

        wait_idle();
        if (mismatches == 0 && cell_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// ===== display_line_dirty_update.f =====
hw/rtl/dldu_pkg.sv
hw/rtl/dldu_cache.sv
hw/rtl/display_line_dirty_update.sv
verif/tb.sv
